// ===== src/atan2_continued_fraction_core_assert.svh =====
// Assertion macros for the atan2 core
`ifndef ATAN2_CONTINUED_FRACTION_CORE_ASSERT_SVH
`define ATAN2_CONTINUED_FRACTION_CORE_ASSERT_SVH

// checked only out of reset
`define A2CF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge
`define A2CF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== src/a2cf_pkg.sv =====
package a2cf_pkg;

    localparam int unsigned FRAC_C  = 26;
    localparam int unsigned T_W     = 31;
    localparam int unsigned SQ_W    = 27;
    localparam int unsigned C_W     = 30;
    localparam int unsigned NUM_W   = 37;
    localparam int unsigned DEN_W   = 33;
    localparam int unsigned ZSQ_W   = 11;
    localparam int unsigned ODD_W   = 7;
    localparam int unsigned A_W     = 29;
    localparam int unsigned ANGLE_W = 31;

    localparam logic [29:0] PI_Q28      = 30'd843314857;
    localparam logic [28:0] HALF_PI_Q28 = 29'd421657428;

    typedef struct packed {
        logic yneg;
        logic xneg;
        logic steep;
        logic both_zero;
        logic x_zero;
    } a2cf_flags_t;

endpackage

// ===== src/atan2_continued_fraction_core.sv =====
// Four-quadrant arctangent, atan2(y, x), by a Gauss continued fraction.
// Input channel s_*: one item holds y (s_tdata[31:0]) and x (s_tdata[63:32]),
// both signed Q16.16. Result channel m_*: the angle in m_tdata[30:0], signed
// Q3.28, from -pi to pi; both inputs zero give 0.
// Throughput: one item per cycle while the output is not stalled. The
// pipeline is built from bit-serial pipelined dividers: the ratio divider, one
// divider per continued-fraction term and the final rounding divider, each
// one quotient bit per stage.
// The whole pipeline moves on one enable; while a result sits in the output
// register untaken, every stage holds and s_tready is low. Items already in
// flight are kept, none are dropped or repeated.
// Reset (aresetn low, synchronous) clears all valid bits; the pipeline is
// empty and ready on the first cycle after reset.
module atan2_continued_fraction_core
    import a2cf_pkg::*;
#(
    parameter int unsigned TERMS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // y_value [31:0], x_value [63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // angle [30:0], zero [31]
);

    `include "atan2_continued_fraction_core_assert.svh"

    localparam int unsigned FW = $bits(a2cf_flags_t);
    localparam int unsigned TSW = T_W + SQ_W + FW;

    logic en;
    logic out_valid_reg;
    logic [ANGLE_W-1:0] angle_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // magnitudes
    logic        v1_reg;
    logic [31:0] ay_reg, ax_reg;
    logic        yneg1_reg, xneg1_reg;
    logic [31:0] y_in, x_in;

    assign y_in = s_tdata[31:0];
    assign x_in = s_tdata[63:32];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ay_reg    <= y_in[31] ? (32'd0 - y_in) : y_in;
            ax_reg    <= x_in[31] ? (32'd0 - x_in) : x_in;
            yneg1_reg <= y_in[31];
            xneg1_reg <= x_in[31];
        end
    end

    // min / max and case flags
    logic        v2_reg;
    logic [31:0] mn_reg, mx_reg;
    a2cf_flags_t flags2_reg;
    a2cf_flags_t flags2_next;

    always_comb begin
        flags2_next.yneg      = yneg1_reg;
        flags2_next.xneg      = xneg1_reg;
        flags2_next.steep     = (ay_reg > ax_reg);
        flags2_next.both_zero = (ay_reg == 32'd0) && (ax_reg == 32'd0);
        flags2_next.x_zero    = (ax_reg == 32'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mn_reg     <= flags2_next.steep ? ax_reg : ay_reg;
            mx_reg     <= flags2_next.steep ? ay_reg : ax_reg;
            flags2_reg <= flags2_next;
        end
    end

    // ratio t = min * 2^30 / max
    logic           rv_valid;
    logic [T_W-1:0] rv_t;
    logic [FW-1:0]  rv_side;

    a2cf_divider #(
        .NW(62), .DW(32), .QW(T_W), .SW(FW)
    ) u_ratio (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (v2_reg),
        .in_num   ({mn_reg, 30'd0}),
        .in_den   (mx_reg),
        .in_side  (flags2_reg),
        .out_valid(rv_valid),
        .out_quo  (rv_t),
        .out_side (rv_side)
    );

    // t squared
    logic            v3_reg;
    logic [T_W-1:0]  t3_reg;
    logic [SQ_W-1:0] sq3_reg;
    logic [FW-1:0]   f3_reg;
    logic [61:0]     tt;

    assign tt = {31'd0, rv_t} * {31'd0, rv_t};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= rv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t3_reg  <= rv_t;
            sq3_reg <= tt[60:34];
            f3_reg  <= rv_side;
        end
    end

    // continued fraction, deepest term first
    logic            cv_w  [TERMS+1];
    logic [C_W-1:0]  c_w   [TERMS+1];
    logic [T_W-1:0]  t_w   [TERMS+1];
    logic [SQ_W-1:0] sq_w  [TERMS+1];
    logic [FW-1:0]   f_w   [TERMS+1];

    assign cv_w[0] = v3_reg;
    assign c_w[0]  = '0;
    assign t_w[0]  = t3_reg;
    assign sq_w[0] = sq3_reg;
    assign f_w[0]  = f3_reg;

    for (genvar i = 0; i < TERMS; i++) begin : g_term
        localparam int unsigned Z = TERMS - i;
        localparam logic [ZSQ_W-1:0] ZSQ = ZSQ_W'(Z * Z);
        localparam logic [ODD_W-1:0] ODD = ODD_W'(2 * Z + 1);

        logic             tv_reg;
        logic [NUM_W-1:0] num_reg;
        logic [DEN_W-1:0] den_reg;
        logic [TSW-1:0]   side_reg;
        logic [ZSQ_W+SQ_W-1:0] prod;
        logic [TSW-1:0]   side_out;

        assign prod = {{SQ_W{1'b0}}, ZSQ} * {{ZSQ_W{1'b0}}, sq_w[i]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tv_reg <= 1'b0;
            end else if (en) begin
                tv_reg <= cv_w[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                num_reg  <= prod[NUM_W-1:0];
                den_reg  <= {ODD, {FRAC_C{1'b0}}} + {{(DEN_W-C_W){1'b0}}, c_w[i]};
                side_reg <= {t_w[i], sq_w[i], f_w[i]};
            end
        end

        a2cf_divider #(
            .NW(NUM_W + FRAC_C), .DW(DEN_W), .QW(C_W), .SW(TSW)
        ) u_div (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (tv_reg),
            .in_num   ({num_reg, {FRAC_C{1'b0}}}),
            .in_den   (den_reg),
            .in_side  (side_reg),
            .out_valid(cv_w[i+1]),
            .out_quo  (c_w[i+1]),
            .out_side (side_out)
        );

        assign t_w[i+1]  = side_out[TSW-1 -: T_W];
        assign sq_w[i+1] = side_out[FW +: SQ_W];
        assign f_w[i+1]  = side_out[FW-1:0];
    end

    // a = round(t * 2^24 / (2^26 + c))
    logic        v4_reg;
    logic [54:0] fnum_reg;
    logic [30:0] fden_reg;
    logic [FW-1:0] f4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= cv_w[TERMS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fden_reg <= {1'b0, c_w[TERMS]} + 31'(1 << FRAC_C);
            fnum_reg <= {t_w[TERMS], 24'd0}
                      + {26'd0, c_w[TERMS][C_W-1:1]}
                      + 55'(1 << (FRAC_C - 1));
            f4_reg   <= f_w[TERMS];
        end
    end

    logic           av_valid;
    logic [A_W-1:0] av_q;
    logic [FW-1:0]  av_side;

    a2cf_divider #(
        .NW(55), .DW(31), .QW(A_W), .SW(FW)
    ) u_final (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (v4_reg),
        .in_num   (fnum_reg),
        .in_den   (fden_reg),
        .in_side  (f4_reg),
        .out_valid(av_valid),
        .out_quo  (av_q),
        .out_side (av_side)
    );

    // octant fold
    logic           v5_reg;
    logic [A_W-1:0] a5_reg;
    a2cf_flags_t    f5_reg;
    a2cf_flags_t    av_flags;

    assign av_flags = av_side;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= av_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a5_reg <= av_flags.steep ? (HALF_PI_Q28 - av_q) : av_q;
            f5_reg <= av_flags;
        end
    end

    // quadrant and special cases
    logic [29:0]        quad;
    logic [ANGLE_W-1:0] angle_next;

    assign quad = f5_reg.xneg ? (PI_Q28 - {1'b0, a5_reg}) : {1'b0, a5_reg};

    always_comb begin
        if (f5_reg.both_zero) begin
            angle_next = '0;
        end else if (f5_reg.x_zero) begin
            angle_next = f5_reg.yneg ? (31'd0 - {2'b0, HALF_PI_Q28}) : {2'b0, HALF_PI_Q28};
        end else begin
            angle_next = f5_reg.yneg ? (31'd0 - {1'b0, quad}) : {1'b0, quad};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            angle_reg <= angle_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, angle_reg};

    localparam logic signed [ANGLE_W-1:0] PI_S = $signed({1'b0, PI_Q28});
    logic signed [ANGLE_W-1:0] angle_s;

    assign angle_s = $signed(angle_reg);

    `A2CF_ASSERT(a_angle_range, m_tvalid |-> (angle_s <= PI_S && angle_s >= -PI_S), "angle out of range")
    `A2CF_ASSERT(a_stall_blocks, (m_tvalid && !m_tready) |-> !s_tready, "item taken during stall")
    `A2CF_ASSERT(a_stall_keeps, (m_tvalid && !m_tready) |=> m_tvalid, "result lost during stall")

endmodule

// ===== src/a2cf_divider.sv =====
module a2cf_divider #(
    parameter int unsigned NW = 62,
    parameter int unsigned DW = 32,
    parameter int unsigned QW = 31,
    parameter int unsigned SW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_den,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [QW-1:0] out_quo,
    output logic [SW-1:0] out_side
);

    // restoring division, one quotient bit per stage
    logic          valid_reg [QW];
    logic [DW-1:0] rem_reg   [QW];
    logic [QW-1:0] low_reg   [QW];
    logic [QW-1:0] quo_reg   [QW];
    logic [DW-1:0] den_reg   [QW];
    logic [SW-1:0] side_reg  [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic          valid_in;
        logic [DW-1:0] rem_in;
        logic [QW-1:0] low_in;
        logic [QW-1:0] quo_in;
        logic [DW-1:0] den_in;
        logic [SW-1:0] side_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          fits;
        logic [DW-1:0] rem_next;
        logic [QW-1:0] quo_next;

        if (j == 0) begin : g_first
            assign valid_in = in_valid;
            assign rem_in   = DW'(in_num >> QW);
            assign low_in   = in_num[QW-1:0];
            assign quo_in   = '0;
            assign den_in   = in_den;
            assign side_in  = in_side;
        end else begin : g_next
            assign valid_in = valid_reg[j-1];
            assign rem_in   = rem_reg[j-1];
            assign low_in   = low_reg[j-1];
            assign quo_in   = quo_reg[j-1];
            assign den_in   = den_reg[j-1];
            assign side_in  = side_reg[j-1];
        end

        assign trial    = {rem_in, low_in[QW-1]};
        assign diff     = trial - {1'b0, den_in};
        assign fits     = (trial >= {1'b0, den_in});
        assign rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
        assign quo_next = {quo_in[QW-2:0], fits};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[j] <= 1'b0;
            end else if (en) begin
                valid_reg[j] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j]  <= rem_next;
                low_reg[j]  <= {low_in[QW-2:0], 1'b0};
                quo_reg[j]  <= quo_next;
                den_reg[j]  <= den_in;
                side_reg[j] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_quo   = quo_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

// ===== verif/testbench.sv =====
module testbench;
    import a2cf_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    localparam int LATENCY = 66 + 31 * 24;

    logic [30:0] angle_queue[$];
    int          fail_count;
    int          rx_idle;
    bit          sender_idle_on;
    bit          receiver_idle_on;
    bit          hold_receiver;

    atan2_continued_fraction_core #(.TERMS(24)) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20000000;
        $display("status: fail");
        $finish;
    end

    function automatic logic [63:0] abs32(logic [31:0] v);
        return v[31] ? 64'h1_0000_0000 - {32'd0, v} : {32'd0, v};
    endfunction

    function automatic logic [63:0] atan_q28(logic [63:0] t);
        logic [63:0] sq;
        logic [63:0] cf;
        logic [63:0] den;
        sq = (t * t) >> 34;
        cf = 0;
        for (int z = 24; z > 0; z--) begin
            den = ((64'(2 * z + 1)) << 26) + cf;
            cf = ((64'(z * z) * sq) << 26) / den;
        end
        den = (64'd1 << 26) + cf;
        return ((t << 24) + den / 2) / den;
    endfunction

    function automatic logic [30:0] predict_angle(logic [31:0] y, logic [31:0] x);
        logic [63:0] ay;
        logic [63:0] ax;
        logic [63:0] a;
        logic [63:0] res;
        ay = abs32(y);
        ax = abs32(x);
        if (ay == 0 && ax == 0) begin
            res = 0;
        end else if (ax == 0) begin
            res = y[31] ? -64'(HALF_PI_Q28) : 64'(HALF_PI_Q28);
        end else begin
            if (ay > ax) begin
                a = 64'(HALF_PI_Q28) - atan_q28((ax << 30) / ay);
            end else begin
                a = atan_q28((ay << 30) / ax);
            end
            if (x[31]) begin
                a = 64'(PI_Q28) - a;
            end
            res = y[31] ? -a : a;
        end
        return res[30:0];
    endfunction

    task automatic send_point(logic [31:0] y, logic [31:0] x);
        int gap;
        if (sender_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {x, y};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        angle_queue.push_back(predict_angle(y, x));
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (angle_queue.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 255) - 128;
            1: return $urandom_range(0, 131071) - 65536;
            2: return {{16{1'b0}}, 16'($urandom)} ^ {32{$urandom_range(0, 1) == 1}};
            default: return $urandom;
        endcase
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_idle = 0;
        end else if (hold_receiver) begin
            m_tready <= 1'b0;
        end else if (rx_idle > 0) begin
            m_tready <= 1'b0;
            rx_idle--;
        end else if (receiver_idle_on && $urandom_range(0, 7) == 0) begin
            m_tready <= 1'b0;
            rx_idle = $urandom_range(0, 11);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (angle_queue.size() == 0) begin
                $error("unexpected item, angle=%0d", $signed(m_tdata[30:0]));
                fail_count++;
            end else begin
                logic [30:0] want;
                want = angle_queue.pop_front();
                if (m_tdata[30:0] !== want) begin
                    $error("angle expected %0d actual %0d", $signed(want),
                           $signed(m_tdata[30:0]));
                    fail_count++;
                end
            end
        end
    end

    task automatic test_directed;
        logic [31:0] edge_vals[8];
        edge_vals = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h0001_0000, 32'hFFFF_0000, 32'h5555_AAAA};
        send_point(0, 0);
        send_point(32'h0001_0000, 0);
        send_point(32'hFFFF_0000, 0);
        send_point(0, 32'hFFFF_0000);
        send_point(0, 32'h0001_0000);
        send_point(32'h0001_0000, 32'h0001_0000);
        send_point(32'hFFFF_0000, 32'hFFFF_0000);
        send_point(32'h8000_0000, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 0);
        send_point(32'h1, 32'h7FFF_FFFF);
        send_point(32'h7FFF_FFFF, 32'h1);
        for (int i = 0; i < 10; i++) begin
            send_point(edge_vals[$urandom_range(0, 7)], edge_vals[$urandom_range(0, 7)]);
        end
        drain();
    endtask

    task automatic test_backpressure;
        int held;
        hold_receiver = 1'b1;
        fork
            begin
                held = 0;
                while (held < LATENCY + 200) begin
                    @(posedge aclk);
                    held++;
                end
                hold_receiver = 1'b0;
            end
            while (hold_receiver) send_point($urandom, $urandom);
        join
        drain();
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) begin
            send_point(rand_coord(), rand_coord());
        end
    endtask

    initial begin
        aresetn          = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        fail_count       = 0;
        sender_idle_on   = 1'b1;
        receiver_idle_on = 1'b1;
        hold_receiver    = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_random(450);
        sender_idle_on   = 1'b0;
        receiver_idle_on = 1'b0;
        test_random(270);
        drain();
        repeat (LATENCY + 20) @(posedge aclk);
        if (fail_count == 0 && angle_queue.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== atan2_continued_fraction_core.f =====
+incdir+src
src/a2cf_pkg.sv
src/a2cf_divider.sv
src/atan2_continued_fraction_core.sv
verif/testbench.sv
